// File: hdl/smsr_pkg.sv
package smsr_pkg;

  // field widths
  localparam int unsigned BYTES_W = 20;
  localparam int unsigned QS_W    = 15;
  localparam int unsigned OQS_W   = 5;
  localparam int unsigned GUARD_W = 24;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TOTAL_W = 36;
  localparam int unsigned RATE_W  = 48;
  localparam int unsigned PIC_W   = 16;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 2;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = TOTAL_W;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // shared divider widths: dividend covers 90000*total + delta
  localparam int unsigned DVD_W   = 54;
  localparam int unsigned DVS_W   = 32;
  localparam int unsigned DCNT_W  = $clog2(DVD_W + 1);

  // fraction bits of the quant scale, shift from a byte count to a bit count
  localparam int unsigned QS_FRAC = 8;
  localparam int unsigned BYTE_SH = 3;

  // size reduction divides the product with its fraction bits dropped
  localparam int unsigned RED_W   = BYTES_W + QS_W - QS_FRAC;

  // two times the tick rate, for a rounded rate quotient
  localparam logic [MUL_B_W-1:0] RATE_SCALE = MUL_B_W'(90000);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [RATE_W-1:0]  RATE_MAX  = {RATE_W{1'b1}};

  localparam logic [GUARD_W-1:0] GUARD_RST = GUARD_W'(9400);

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_GUARD_BITS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PCR_OFFSET = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_OUT_QS     = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DCNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// File: hdl/smsr_mul.sv
module smsr_mul
  import smsr_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [MUL_P_W-1:0] prod
);

  logic [MUL_P_W-1:0] prod_r;

  // register the product of the selected operands
  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// File: hdl/smsr_div.sv
module smsr_div
  import smsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_rsp_t         rsp,
  output logic [DVD_W-1:0] quotient
);

  logic [DVS_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;
  logic [DVS_W-1:0]  rem_nxt;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    ge      = (trial >= {1'b0, dvs_r});
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // control: load on start, count down the steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: the quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/statmux_min_send_rate.sv
// Minimum send rate tracker for one video program. Each accepted word is one
// picture in decode order; each produces exactly one result word. The block
// works on one picture at a time around a shared registered multiplier and a
// radix-2 restoring divider that yields one quotient bit per cycle. A counted
// picture whose size is cut runs two divisions between acceptance and the
// edge that loads its result: one over the 27-bit reduced product for the
// size reduction, then one over the 54-bit dividend for the rate. An uncut
// picture skips the first division; a zero or negative deadline skips the
// second; an uncounted picture skips the rate work. The sequencer returns
// to its idle state before the next picture is taken, and a result that
// cannot leave holds the sequencer until the result register frees up.
// in_stall is high while a picture is in work; the result register lets the
// next picture be accepted while the previous result still waits.
// Configuration writes are always taken (cfg_ready is held high) and must be
// made while idle.
module statmux_min_send_rate
  import smsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CIDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_window_start,
  input  logic [TIME_W-1:0]         in_now_time,
  input  logic                      in_is_partial,
  input  logic                      in_in_lookahead,
  input  logic [BYTES_W-1:0]        in_orig_bytes,
  input  logic [QS_W-1:0]           in_avg_qs,
  input  logic [TIME_W-1:0]         in_dts,
  input  logic [PIC_W-1:0]          in_pic_number,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [BYTES_W-1:0]        out_target_bytes,
  output logic [TOTAL_W-1:0]        out_acc_bits,
  output logic signed [TIME_W-1:0]  out_deadline_delta,
  output logic [RATE_W-1:0]         out_pic_rate,
  output logic [RATE_W-1:0]         out_max_rate,
  output logic [PIC_W-1:0]          out_max_pic,
  output logic [RATE_W-1:0]         out_leftover_rate,
  output logic                      out_bad_delta
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TGT,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_ACC,
    S_RMUL,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_UPD,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [GUARD_W-1:0] guard_bits_r;
  logic [TIME_W-1:0]  pcr_offset_r;
  logic [OQS_W-1:0]   out_qs_r;

  // picture being worked on
  logic               partial_r;
  logic               lah_r;
  logic [BYTES_W-1:0] orig_r;
  logic [QS_W-1:0]    qs_r;
  logic [TIME_W-1:0]  dts_r;
  logic [PIC_W-1:0]   pic_r;
  logic [BYTES_W-1:0] target_r;
  logic [TIME_W-1:0]  delta_r;
  logic [RATE_W-1:0]  rate_r;
  logic               bad_r;

  // running state
  logic [TOTAL_W-1:0] bit_total_r;
  logic [RATE_W-1:0]  best_rate_r;
  logic [PIC_W-1:0]   best_pic_r;
  logic [RATE_W-1:0]  partial_rate_r;
  logic [TIME_W-1:0]  window_time_r;

  // result register
  logic               out_valid_r;
  logic [BYTES_W-1:0] o_target_r;
  logic [TOTAL_W-1:0] o_acc_r;
  logic [TIME_W-1:0]  o_delta_r;
  logic [RATE_W-1:0]  o_rate_r;
  logic [RATE_W-1:0]  o_max_r;
  logic [PIC_W-1:0]   o_pic_r;
  logic [RATE_W-1:0]  o_left_r;
  logic               o_bad_r;

  logic               in_acc;
  logic               out_free;
  logic               reduce;
  logic               counted;
  logic               delta_bad;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_nxt;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  div_req_t           dreq;
  div_rsp_t           drsp;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVD_W-1:0]   quo;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // compare at the full quant scale width
  assign reduce    = !partial_r &&
                     (QS_W'({out_qs_r, QS_FRAC'(0)}) > qs_r);
  assign counted   = partial_r || lah_r;
  assign delta_bad = (delta_r == '0) || delta_r[TIME_W-1];

  // saturating add of the picture's bits
  assign sum       = {1'b0, bit_total_r} +
                     (TOTAL_W + 1)'({target_r, BYTE_SH'(0)});
  assign total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // operand select for the shared multiplier
  always_comb begin
    if (state_r == S_RMUL) begin
      mul_a = bit_total_r;
      mul_b = RATE_SCALE;
    end else begin
      mul_a = MUL_A_W'(orig_r);
      mul_b = MUL_B_W'(qs_r);
    end
  end

  smsr_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // operand select for the shared divider
  always_comb begin
    dreq.start = 1'b0;
    dreq.steps = DCNT_W'(DVD_W);
    dvd        = '0;
    dvs        = '0;
    unique case (state_r)
      S_DIV1_GO: begin
        dreq.start = 1'b1;
        dreq.steps = DCNT_W'(RED_W);
        dvd        = {prod[BYTES_W+QS_W-1:QS_FRAC], (DVD_W - RED_W)'(0)};
        dvs        = DVS_W'(out_qs_r);
      end
      S_DIV2_GO: begin
        dreq.start = 1'b1;
        dreq.steps = DCNT_W'(DVD_W);
        dvd        = DVD_W'(prod) + DVD_W'(delta_r);
        dvs        = {delta_r[DVS_W-2:0], 1'b0};
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  smsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .dividend (dvd),
    .divisor  (dvs),
    .rsp      (drsp),
    .quotient (quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_bits_r <= GUARD_RST;
      pcr_offset_r <= '0;
      out_qs_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GUARD_BITS: guard_bits_r <= cfg_data[GUARD_W-1:0];
        CFG_PCR_OFFSET: pcr_offset_r <= cfg_data[TIME_W-1:0];
        CFG_OUT_QS:     out_qs_r     <= cfg_data[OQS_W-1:0];
        default:        ;
      endcase
    end
  end

  // sequencer, running state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      bit_total_r    <= '0;
      best_rate_r    <= '0;
      best_pic_r     <= '0;
      partial_rate_r <= '0;
      window_time_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            partial_r <= in_is_partial;
            lah_r     <= in_in_lookahead;
            orig_r    <= in_orig_bytes;
            qs_r      <= in_avg_qs;
            dts_r     <= in_dts;
            pic_r     <= in_pic_number;
            if (in_window_start) begin
              bit_total_r    <= TOTAL_W'(guard_bits_r);
              window_time_r  <= in_now_time;
              best_rate_r    <= '0;
              partial_rate_r <= '0;
            end
            state_r <= S_TGT;
          end
        end
        S_TGT: begin
          delta_r <= dts_r - window_time_r + pcr_offset_r;
          rate_r  <= '0;
          bad_r   <= 1'b0;
          target_r <= orig_r;
          state_r <= reduce ? S_DIV1_GO : S_ACC;
        end
        S_DIV1_GO: begin
          state_r <= S_DIV1_WAIT;
        end
        S_DIV1_WAIT: begin
          if (drsp.done) begin
            target_r <= quo[BYTES_W-1:0];
            state_r  <= S_ACC;
          end
        end
        S_ACC: begin
          if (counted) begin
            bit_total_r <= total_nxt;
            state_r     <= S_RMUL;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_RMUL: begin
          if (delta_bad) begin
            rate_r  <= RATE_MAX;
            bad_r   <= 1'b1;
            state_r <= S_UPD;
          end else begin
            state_r <= S_DIV2_GO;
          end
        end
        S_DIV2_GO: begin
          state_r <= S_DIV2_WAIT;
        end
        S_DIV2_WAIT: begin
          if (drsp.done) begin
            if (quo[DVD_W-1:RATE_W] != '0) begin
              rate_r <= RATE_MAX;
              bad_r  <= 1'b1;
            end else begin
              rate_r <= quo[RATE_W-1:0];
            end
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (partial_r) begin
            partial_rate_r <= rate_r;
            best_rate_r    <= rate_r;
            best_pic_r     <= pic_r;
          end else if (rate_r > best_rate_r) begin
            best_rate_r <= rate_r;
            best_pic_r  <= pic_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold until the result register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_target_r  <= target_r;
            o_acc_r     <= bit_total_r;
            o_delta_r   <= delta_r;
            o_rate_r    <= rate_r;
            o_max_r     <= best_rate_r;
            o_pic_r     <= best_pic_r;
            o_left_r    <= partial_rate_r;
            o_bad_r     <= bad_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target_bytes   = o_target_r;
  assign out_acc_bits       = o_acc_r;
  assign out_deadline_delta = o_delta_r;
  assign out_pic_rate       = o_rate_r;
  assign out_max_rate       = o_max_r;
  assign out_max_pic        = o_pic_r;
  assign out_leftover_rate  = o_left_r;
  assign out_bad_delta      = o_bad_r;

  // a saturated rate always reads as all ones
  a_bad_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_delta |-> out_pic_rate == RATE_MAX)
    else $error("bad_delta without saturated rate");

  // the running maximum never falls below the picture's own rate
  a_max_ge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_rate >= out_pic_rate)
    else $error("max_rate below pic_rate");

  // the divider is only started when idle
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> !drsp.busy && !drsp.done)
    else $error("divider restarted while busy");

  // no word is taken while a picture is in work
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_TGT && in_stall)
    else $error("input taken outside idle");

endmodule

// File: bench/tb.sv
module tb;
  import smsr_pkg::*;

  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned BIG_PICTURES    = 16;
  localparam longint unsigned TICK_RATE   = 45000;

  localparam logic [TOTAL_W-1:0] TOTAL_CAP = {TOTAL_W{1'b1}};
  localparam logic [RATE_W-1:0]  RATE_CAP  = {RATE_W{1'b1}};
  localparam logic [GUARD_W-1:0] GUARD_CAP = {GUARD_W{1'b1}};
  localparam logic [BYTES_W-1:0] BYTES_CAP = {BYTES_W{1'b1}};
  localparam logic [QS_W-1:0]    QS_CAP    = {QS_W{1'b1}};

  typedef struct packed {
    logic               window_start;
    logic [TIME_W-1:0]  now_time;
    logic               is_partial;
    logic               in_lookahead;
    logic [BYTES_W-1:0] orig_bytes;
    logic [QS_W-1:0]    avg_qs;
    logic [TIME_W-1:0]  dts;
    logic [PIC_W-1:0]   pic_number;
  } picture_t;

  typedef struct packed {
    logic [BYTES_W-1:0] target_bytes;
    logic [TOTAL_W-1:0] acc_bits;
    logic [TIME_W-1:0]  deadline_delta;
    logic [RATE_W-1:0]  pic_rate;
    logic [RATE_W-1:0]  max_rate;
    logic [PIC_W-1:0]   max_pic;
    logic [RATE_W-1:0]  leftover_rate;
    logic               bad_delta;
  } pic_result_t;

  // Tracks the send rate of the program and holds the results still owed
  class rate_scoreboard;
    logic [GUARD_W-1:0] guard_bits;
    logic [TIME_W-1:0]  pcr_offset;
    logic [OQS_W-1:0]   out_qs;

    logic [TOTAL_W-1:0] bit_total;
    logic [RATE_W-1:0]  best_rate;
    logic [PIC_W-1:0]   best_pic;
    logic [RATE_W-1:0]  partial_rate;
    logic [TIME_W-1:0]  window_time;

    pic_result_t awaited_results[$];
    int unsigned failures;
    int unsigned results_seen;

    function new();
      guard_bits   = GUARD_W'(9400);
      pcr_offset   = '0;
      out_qs       = '0;
      bit_total    = '0;
      best_rate    = '0;
      best_pic     = '0;
      partial_rate = '0;
      window_time  = '0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void write_register(logic [CIDX_W-1:0] reg_id, logic [CFG_W-1:0] value);
      case (reg_id)
        CFG_GUARD_BITS: guard_bits = value[GUARD_W-1:0];
        CFG_PCR_OFFSET: pcr_offset = value[TIME_W-1:0];
        CFG_OUT_QS:     out_qs     = value[OQS_W-1:0];
        default: ;
      endcase
    endfunction

    // Rate to deliver the total by the deadline, rounded half up
    function logic [RATE_W-1:0] deadline_rate(input logic [TOTAL_W-1:0] total,
                                              input logic [TIME_W-1:0] delta,
                                              output bit bad);
      logic [63:0] quotient;
      bad = 1'b0;
      if (delta == '0 || delta[TIME_W-1]) begin
        bad = 1'b1;
        return RATE_CAP;
      end
      quotient = (64'(total) * (2 * TICK_RATE) + 64'(delta)) / (64'(delta) << 1);
      if (quotient > 64'(RATE_CAP)) begin
        bad = 1'b1;
        return RATE_CAP;
      end
      return quotient[RATE_W-1:0];
    endfunction

    function void note_picture(picture_t p);
      pic_result_t r;
      logic [63:0] grown;
      logic [TIME_W-1:0] delta;
      logic [BYTES_W-1:0] cut_bytes;
      logic [RATE_W-1:0] rate;
      bit bad;
      rate = '0;
      bad  = 1'b0;
      // a new window restarts the total from the guard value
      if (p.window_start) begin
        bit_total    = TOTAL_W'(guard_bits);
        window_time  = p.now_time;
        best_rate    = '0;
        partial_rate = '0;
      end
      delta = p.dts - window_time + pcr_offset;
      cut_bytes = p.orig_bytes;
      if (!p.is_partial && (32'(out_qs) << 8) > 32'(p.avg_qs))
        cut_bytes = BYTES_W'((64'(p.orig_bytes) * 64'(p.avg_qs)) / (64'(out_qs) << 8));
      // leftover and lookahead pictures count towards the total
      if (p.is_partial || p.in_lookahead) begin
        grown = 64'(bit_total) + (64'(cut_bytes) << 3);
        bit_total = (grown > 64'(TOTAL_CAP)) ? TOTAL_CAP : grown[TOTAL_W-1:0];
        rate = deadline_rate(bit_total, delta, bad);
        if (p.is_partial) begin
          partial_rate = rate;
          best_rate    = rate;
          best_pic     = p.pic_number;
        end else if (rate > best_rate) begin
          best_rate = rate;
          best_pic  = p.pic_number;
        end
      end
      r.target_bytes   = cut_bytes;
      r.acc_bits       = bit_total;
      r.deadline_delta = delta;
      r.pic_rate       = rate;
      r.max_rate       = best_rate;
      r.max_pic        = best_pic;
      r.leftover_rate  = partial_rate;
      r.bad_delta      = bad;
      awaited_results.push_back(r);
    endfunction

    function void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("tb: result %0d %s: expected %0h, got %0h",
                   results_seen, field, want, got);
      end
    endfunction

    function void check_result(pic_result_t got);
      pic_result_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("tb: result %0d arrived with nothing outstanding", results_seen);
        return;
      end
      want = awaited_results.pop_front();
      check_field("target_bytes", 64'(want.target_bytes), 64'(got.target_bytes));
      check_field("acc_bits", 64'(want.acc_bits), 64'(got.acc_bits));
      check_field("deadline_delta", 64'(want.deadline_delta), 64'(got.deadline_delta));
      check_field("pic_rate", 64'(want.pic_rate), 64'(got.pic_rate));
      check_field("max_rate", 64'(want.max_rate), 64'(got.max_rate));
      check_field("max_pic", 64'(want.max_pic), 64'(got.max_pic));
      check_field("leftover_rate", 64'(want.leftover_rate), 64'(got.leftover_rate));
      check_field("bad_delta", 64'(want.bad_delta), 64'(got.bad_delta));
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_window_start = 1'b0;
  logic [TIME_W-1:0]        in_now_time = '0;
  logic                     in_is_partial = 1'b0;
  logic                     in_in_lookahead = 1'b0;
  logic [BYTES_W-1:0]       in_orig_bytes = '0;
  logic [QS_W-1:0]          in_avg_qs = '0;
  logic [TIME_W-1:0]        in_dts = '0;
  logic [PIC_W-1:0]         in_pic_number = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [BYTES_W-1:0]       out_target_bytes;
  logic [TOTAL_W-1:0]       out_acc_bits;
  logic signed [TIME_W-1:0] out_deadline_delta;
  logic [RATE_W-1:0]        out_pic_rate;
  logic [RATE_W-1:0]        out_max_rate;
  logic [PIC_W-1:0]         out_max_pic;
  logic [RATE_W-1:0]        out_leftover_rate;
  logic                     out_bad_delta;

  rate_scoreboard sb;

  // stream shaping state
  bit                 calm = 1'b0;
  int unsigned        hold_requests = 0;
  int unsigned        quiet_cycles = 0;
  logic [TIME_W-1:0]  cur_offset = '0;
  logic [OQS_W-1:0]   cur_qs = '0;
  logic [TIME_W-1:0]  win_now = '0;
  int                 win_left = 0;
  int                 lah_left = 0;
  int                 delta_ticks = 0;
  logic [PIC_W-1:0]   next_pic = '0;

  statmux_min_send_rate uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_window_start    (in_window_start),
    .in_now_time        (in_now_time),
    .in_is_partial      (in_is_partial),
    .in_in_lookahead    (in_in_lookahead),
    .in_orig_bytes      (in_orig_bytes),
    .in_avg_qs          (in_avg_qs),
    .in_dts             (in_dts),
    .in_pic_number      (in_pic_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_target_bytes   (out_target_bytes),
    .out_acc_bits       (out_acc_bits),
    .out_deadline_delta (out_deadline_delta),
    .out_pic_rate       (out_pic_rate),
    .out_max_rate       (out_max_rate),
    .out_max_pic        (out_max_pic),
    .out_leftover_rate  (out_leftover_rate),
    .out_bad_delta      (out_bad_delta)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic picture_t make_pic(bit ws, logic [TIME_W-1:0] now, bit part, bit lah,
                                        logic [BYTES_W-1:0] orig, logic [QS_W-1:0] qs,
                                        logic [TIME_W-1:0] dts, logic [PIC_W-1:0] num);
    picture_t p;
    p.window_start = ws;
    p.now_time     = now;
    p.is_partial   = part;
    p.in_lookahead = lah;
    p.orig_bytes   = orig;
    p.avg_qs       = qs;
    p.dts          = dts;
    p.pic_number   = num;
    return p;
  endfunction

  // Next picture of a plausible program stream, with some noise mixed in
  function automatic picture_t stream_picture();
    picture_t p;
    int unsigned roll;
    int centre;
    p = '0;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      p.window_start = 1'($urandom_range(0, 1));
      p.now_time     = $urandom;
      p.is_partial   = 1'($urandom_range(0, 1));
      p.in_lookahead = 1'($urandom_range(0, 1));
      p.orig_bytes   = BYTES_W'($urandom);
      p.avg_qs       = QS_W'($urandom);
      p.dts          = $urandom;
      p.pic_number   = PIC_W'($urandom);
      if (p.window_start) win_now = p.now_time;
      return p;
    end
    // open a window, often on the leftover of a partly sent picture
    if (win_left <= 0) begin
      win_left = $urandom_range(2, 14);
      lah_left = $urandom_range(1, win_left);
      win_now  = $urandom;
      if ($urandom_range(0, 19) == 0) delta_ticks = -int'($urandom_range(0, 4000));
      else delta_ticks = $urandom_range(0, 6000);
      p.window_start = 1'b1;
      p.is_partial   = ($urandom_range(0, 2) == 0);
    end else if ($urandom_range(0, 39) == 0) begin
      p.is_partial = 1'b1;
    end
    p.now_time = p.window_start ? win_now : $urandom;
    p.in_lookahead = p.is_partial ? 1'($urandom_range(0, 1)) : (lah_left > 0);
    if (lah_left > 0) lah_left--;
    win_left--;
    p.dts = win_now - cur_offset + TIME_W'(delta_ticks);
    delta_ticks += $urandom_range(0, 4000);
    roll = $urandom_range(0, 99);
    if (roll < 10) p.orig_bytes = '0;
    else if (roll < 20) p.orig_bytes = BYTES_CAP;
    else if (roll < 50) p.orig_bytes = BYTES_W'($urandom);
    else p.orig_bytes = BYTES_W'($urandom_range(1000, 150000));
    roll = $urandom_range(0, 99);
    if (roll < 10) p.avg_qs = '0;
    else if (roll < 20) p.avg_qs = QS_CAP;
    else if (roll < 60) p.avg_qs = QS_W'($urandom);
    else begin
      // close to the reduction threshold on either side
      centre = int'(cur_qs) * 256 + int'($urandom_range(0, 1200)) - 600;
      if (centre < 0) centre = 0;
      if (centre > int'(QS_CAP)) centre = int'(QS_CAP);
      p.avg_qs = QS_W'(centre);
    end
    p.pic_number = next_pic;
    next_pic++;
    return p;
  endfunction

  // Offer one picture after an optional gap and hold it until taken
  task automatic send_picture(picture_t p, int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_window_start <= p.window_start;
    in_now_time     <= p.now_time;
    in_is_partial   <= p.is_partial;
    in_in_lookahead <= p.in_lookahead;
    in_orig_bytes   <= p.orig_bytes;
    in_avg_qs       <= p.avg_qs;
    in_dts          <= p.dts;
    in_pic_number   <= p.pic_number;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_picture(p);
  endtask

  // Write all three registers back to back, valid held high between words
  task automatic write_settings(logic [GUARD_W-1:0] guard, logic [TIME_W-1:0] offset,
                                logic [OQS_W-1:0] qs);
    logic [CIDX_W-1:0] reg_ids [3];
    logic [CFG_W-1:0]  reg_values [3];
    reg_ids    = '{CFG_GUARD_BITS, CFG_PCR_OFFSET, CFG_OUT_QS};
    reg_values = '{CFG_W'(guard), CFG_W'(offset), CFG_W'(qs)};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_ids[k];
      cfg_data  <= reg_values[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_register(reg_ids[k], reg_values[k]);
    end
    cfg_valid  <= 1'b0;
    cur_offset = offset;
    cur_qs     = qs;
  endtask

  task automatic wait_for_results();
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_list(picture_t list[$]);
    foreach (list[k]) send_picture(list[k], gap_length());
    in_valid <= 1'b0;
    wait_for_results();
  endtask

  task automatic run_stream(int unsigned count, bit with_hold);
    int unsigned burst_end;
    int unsigned gap;
    burst_end = 0;
    win_left  = 0;
    for (int unsigned i = 0; i < count; i++) begin
      // switch idling off and on again now and then
      if ($urandom_range(0, 29) == 0) calm = !calm;
      // hold the receiver off while pictures keep coming back to back
      if (with_hold && i == count / 3) begin
        hold_requests++;
        burst_end = i + 40;
      end
      gap = (calm || i < burst_end) ? 0 : gap_length();
      send_picture(stream_picture(), gap);
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    wait_for_results();
  endtask

  // Receiver: random stalls, calm stretches and the odd long hold-off
  initial begin : receiver
    int unsigned served;
    int unsigned span;
    bit hold;
    served = 0;
    forever begin
      if (hold_requests != served) begin
        served = hold_requests;
        hold   = 1'b1;
        span   = HOLD_OFF_CYCLES;
      end else if (calm || $urandom_range(0, 1) == 0) begin
        hold = 1'b0;
        span = $urandom_range(1, 12);
      end else begin
        hold = 1'b1;
        span = 1 + gap_length();
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  // Check every result word taken by the receiver
  always @(posedge clk) begin : result_monitor
    pic_result_t seen;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      seen.target_bytes   = out_target_bytes;
      seen.acc_bits       = out_acc_bits;
      seen.deadline_delta = out_deadline_delta;
      seen.pic_rate       = out_pic_rate;
      seen.max_rate       = out_max_rate;
      seen.max_pic        = out_max_pic;
      seen.leftover_rate  = out_leftover_rate;
      seen.bad_delta      = out_bad_delta;
      sb.check_result(seen);
    end
  end

  // Give up when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    picture_t checks[$];
    picture_t p;
    int d;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: guard 9400, no offset, no reduction
    checks.push_back(make_pic(1, 32'd1000, 1, 0, 20'd5000, 15'd0, 32'd4000, 16'd10));
    checks.push_back(make_pic(0, 32'hFFFF_FFFF, 0, 1, BYTES_CAP, QS_CAP, 32'd2500, 16'd11));
    checks.push_back(make_pic(0, 32'd0, 0, 1, 20'd0, 15'd0, 32'd90000, 16'd12));
    checks.push_back(make_pic(0, 32'd0, 0, 0, BYTES_CAP, 15'd0, 32'd5000, 16'd13));
    checks.push_back(make_pic(0, 32'd0, 0, 1, 20'd100, 15'd256, 32'd1000, 16'd14));
    checks.push_back(make_pic(0, 32'd0, 0, 1, 20'd100, 15'd256, 32'd999, 16'd15));
    checks.push_back(make_pic(0, 32'd0, 1, 1, 20'd2000, 15'd0, 32'd1001, 16'hFFFF));
    // window at the top of the time range, deadline wraps round to one tick
    checks.push_back(make_pic(1, 32'hFFFF_FFFF, 0, 1, BYTES_CAP, 15'd0, 32'd0, 16'd0));
    checks.push_back(make_pic(0, 32'd0, 0, 0, 20'd7, 15'd9, 32'h7FFF_FFFE, 16'd16));
    checks.push_back(make_pic(1, 32'd0, 0, 0, 20'd1, 15'd0, 32'hFFFF_FFFF, 16'd20));
    checks.push_back(make_pic(1, 32'd500, 1, 0, BYTES_CAP, 15'd0, 32'd400, 16'd21));
    run_list(checks);

    // strongest reduction, largest positive offset
    write_settings('0, 32'h7FFF_FFFF, 5'd31);
    checks.delete();
    checks.push_back(make_pic(1, 32'd0, 0, 1, BYTES_CAP, 15'd0, 32'd0, 16'd30));
    checks.push_back(make_pic(0, 32'd0, 0, 1, BYTES_CAP, 15'd7935, 32'd0, 16'd31));
    checks.push_back(make_pic(0, 32'd0, 0, 1, BYTES_CAP, 15'd7936, 32'd0, 16'd32));
    checks.push_back(make_pic(0, 32'd0, 1, 0, BYTES_CAP, 15'd1, 32'd5, 16'd33));
    checks.push_back(make_pic(0, 32'd0, 0, 1, 20'd12345, QS_CAP, 32'hFFFF_FFFF, 16'd34));
    run_list(checks);

    // largest guard, most negative offset, mildest reduction
    write_settings(GUARD_CAP, 32'h8000_0000, 5'd1);
    checks.delete();
    checks.push_back(make_pic(1, 32'h1234_5678, 0, 1, 20'hABCDE, 15'd255, 32'h9234_5679,
                              16'd40));
    checks.push_back(make_pic(0, 32'd0, 0, 1, 20'h54321, 15'd256, 32'h1234_5678, 16'd41));
    run_list(checks);

    // random streams under a spread of settings
    next_pic = PIC_W'($urandom);
    write_settings(GUARD_W'($urandom), 32'd3000, 5'd12);
    run_stream(140, 1'b1);
    write_settings('0, 32'h8000_0000, 5'd31);
    run_stream(130, 1'b0);
    write_settings(GUARD_CAP, 32'h7FFF_FFFF, 5'd1);
    run_stream(130, 1'b0);
    write_settings(GUARD_W'($urandom), $urandom, OQS_W'($urandom));
    run_stream(140, 1'b1);
    write_settings(GUARD_W'(9400), '0, '0);
    run_stream(130, 1'b0);

    // one window of the largest pictures from the largest guard;
    // most deadlines are already past, a few are a handful of ticks away
    write_settings(GUARD_CAP, $urandom, '0);
    calm = 1'b1;
    win_now = $urandom;
    for (int unsigned i = 0; i < BIG_PICTURES; i++) begin
      p = '0;
      p.window_start = (i == 0);
      p.now_time     = win_now;
      p.is_partial   = ($urandom_range(0, 15) == 0);
      p.in_lookahead = p.is_partial ? 1'($urandom_range(0, 1)) : 1'b1;
      p.orig_bytes   = BYTES_CAP;
      p.avg_qs       = QS_W'($urandom);
      if ($urandom_range(0, 39) == 0) d = $urandom_range(1, 16);
      else d = -int'($urandom_range(0, 5000));
      p.dts        = win_now - cur_offset + TIME_W'(d);
      p.pic_number = PIC_W'(i);
      send_picture(p, 0);
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    wait_for_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.awaited_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
